// ===== hdl/bcp_pkg.sv =====
// Package for the bracket command parser: word types, characters, reply table.
package bcp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int PAYLOAD_DEPTH = 4;
  localparam int REPLY_LEN = 6;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_K      = 8'h4B;

  typedef enum logic [1:0] {
    REPLY_NONE,
    REPLY_C1,
    REPLY_C2
  } reply_t;

  typedef logic [2:0] char_idx_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       tank1_level;
    logic       tank2_level;
    logic       main_tank_full;
  } in_t;

  typedef struct packed {
    logic       valve_on;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       last;
    logic [7:0] auto_mode;
  } out_t;

  typedef struct packed {
    logic       valve_on;
    logic [7:0] auto_mode;
    reply_t     reply;
  } job_t;

  function automatic logic [7:0] reply_char(reply_t r, char_idx_t idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_LBRACK;
      3'd1:    c = CH_C;
      3'd2:    c = (r == REPLY_C1) ? CH_1 : CH_2;
      3'd3:    c = CH_O;
      3'd4:    c = CH_K;
      3'd5:    c = CH_RBRACK;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/bcp_front.sv =====
// Front end: frame parser, command decode, flag registers and valve rule.
module bcp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bcp_pkg::in_t  in_word,
  input  logic          q_full,
  output logic          q_push,
  output bcp_pkg::job_t q_job
);

  logic                                    in_frame;
  logic [2:0]                              fill_count;
  logic [bcp_pkg::PAYLOAD_DEPTH-1:0][7:0] payload;
  logic [7:0]                              manual_flag;
  logic [7:0]                              auto_flag;

  logic                                    in_frame_next;
  logic [2:0]                              fill_count_next;
  logic [7:0]                              manual_flag_next;
  logic [7:0]                              auto_flag_next;
  logic                                    store;
  logic [7:0]                              digit;
  bcp_pkg::reply_t                         reply;
  logic                                    accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign digit    = payload[3] - bcp_pkg::CH_0;

  always_comb begin
    in_frame_next    = in_frame;
    fill_count_next  = fill_count;
    manual_flag_next = manual_flag;
    auto_flag_next   = auto_flag;
    store            = 1'b0;
    reply            = bcp_pkg::REPLY_NONE;
    if (in_word.func) begin
      if (in_word.rx_byte == bcp_pkg::CH_LBRACK) begin
        fill_count_next = 3'd0;
        in_frame_next   = 1'b1;
      end else if (in_word.rx_byte == bcp_pkg::CH_RBRACK && in_frame) begin
        in_frame_next = 1'b0;
        if (payload[0] == bcp_pkg::CH_V && payload[1] == bcp_pkg::CH_2 &&
            payload[2] == bcp_pkg::CH_V) begin
          manual_flag_next = digit;
          reply            = bcp_pkg::REPLY_C1;
        end else if (payload[0] == bcp_pkg::CH_A && payload[1] == bcp_pkg::CH_U &&
                     payload[2] == bcp_pkg::CH_T) begin
          auto_flag_next = digit;
          reply          = bcp_pkg::REPLY_C2;
        end
      end else if (in_frame && !fill_count[2]) begin
        store           = 1'b1;
        fill_count_next = fill_count + 3'd1;
      end
    end
  end

  always_comb begin
    q_job.reply     = reply;
    q_job.auto_mode = auto_flag_next;
    if (auto_flag_next == 8'd1) begin
      q_job.valve_on = (!in_word.tank1_level || !in_word.tank2_level) &&
                       !in_word.main_tank_full;
    end else begin
      q_job.valve_on = !in_word.main_tank_full && (manual_flag_next == 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      fill_count  <= 3'd0;
      payload     <= '0;
      manual_flag <= 8'd0;
      auto_flag   <= 8'd0;
    end else if (accept) begin
      in_frame    <= in_frame_next;
      fill_count  <= fill_count_next;
      manual_flag <= manual_flag_next;
      auto_flag   <= auto_flag_next;
      if (store) begin
        payload[fill_count[1:0]] <= in_word.rx_byte;
      end
    end
  end

endmodule

// ===== hdl/bcp_queue.sv =====
// Short job queue between front end and reply sequencer.
module bcp_queue #(
  parameter int DEPTH = bcp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bcp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output bcp_pkg::job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bcp_pkg::job_t        mem [DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [CW-1:0]        count;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/bcp_back.sv =====
// Back end: expands each job into one status word or a six-word reply.
module bcp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bcp_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output bcp_pkg::out_t out_word
);

  bcp_pkg::char_idx_t idx;
  bcp_pkg::char_idx_t idx_next;
  bcp_pkg::out_t      word;
  logic               load;
  logic               is_last;
  logic               has_reply;

  assign load      = !out_valid || !out_stall;
  assign has_reply = (q_job.reply != bcp_pkg::REPLY_NONE);
  assign is_last   = !has_reply || (idx == 3'(bcp_pkg::REPLY_LEN - 1));
  assign q_pop     = load && q_valid && is_last;

  always_comb begin
    word.valve_on  = q_job.valve_on;
    word.auto_mode = q_job.auto_mode;
    word.tx_valid  = has_reply;
    word.tx_char   = has_reply ? bcp_pkg::reply_char(q_job.reply, idx) : 8'h00;
    word.last      = is_last;
    idx_next       = idx;
    if (load && q_valid) begin
      idx_next = is_last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_word <= word;
    end
  end

endmodule

// ===== hdl/bracket_command_parser_valve_control.sv =====
// Top level: bracket command parser with transfer-valve control.
// The first result word passes through the job queue and then the output register.
// Throughput: one input word per cycle while the job queue is not full; a reply gives one output word per byte.
// The job queue (QUEUE_DEPTH entries) absorbs input while replies drain.
// Reset clears the frame state, payload bytes, both flags, the queue and the output valid flag.
module bracket_command_parser_valve_control #(
  parameter int QUEUE_DEPTH = bcp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bcp_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output bcp_pkg::out_t out_word
);

  logic          q_full;
  logic          q_push;
  bcp_pkg::job_t q_in_job;
  logic          q_pop;
  logic          q_valid;
  bcp_pkg::job_t q_head_job;

  bcp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_in_job)
  );

  bcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  bcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
